>>> rtl/gwl_pkg.sv
// shared types and constants of the greedy word wrap layout core
package gwl_pkg;

  // character codes that separate words
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_LINE_WIDTH = 2'd0;
  localparam cfg_idx_t CFG_LAST_ROW   = 2'd1;

  // configuration reset values
  localparam logic [7:0] LINE_WIDTH_RST = 8'd38;
  localparam logic [5:0] LAST_ROW_RST   = 6'd18;

  // one input character
  typedef struct packed {
    logic [7:0] ch;
    logic       first_of_text;
    logic       last_of_text;
  } in_t;

  // one placed character
  typedef struct packed {
    logic [7:0] glyph;
    logic [7:0] cell_col;
    logic [5:0] cell_row;
    logic       run_end;
  } out_t;

endpackage

>>> rtl/gwl_word_buf.sv
// word buffer memory, one write port and one registered read port
module gwl_word_buf #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/gwl_col_add.sv
// shared column adder: raw sum for the wrap test and saturated sum for columns
module gwl_col_add #(
  parameter int unsigned B_W = 6
) (
  input  logic [7:0]     a_i,
  input  logic [B_W-1:0] b_i,
  output logic [8:0]     sum_o,
  output logic [7:0]     sat_o
);

  assign sum_o = 9'(a_i) + 9'(b_i);
  // clamp at column 255
  assign sat_o = sum_o[8] ? 8'hFF : sum_o[7:0];

endmodule

>>> rtl/greedy_word_wrap_layout_core.sv
// top level of the greedy word wrap layout core: sequencer, config and output register
//
// channel  direction  handshake                  payload
// cfg      in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
// in       in         in_valid_i  / in_ready_o   in_data_i  (gwl_pkg::in_t)
// out      out        out_valid_o / out_ready_i  out_data_o (gwl_pkg::out_t)
//
// an input character that does not flush leaves the sequencer idle; on a flush the
// stored word is drained one character at a time through ST_RD and ST_EMIT, for the
// registered read of the word memory and the shared column adder
// in_ready_o is high only while the sequencer is idle
// reset clears cursor, word length and config; the word memory has no reset
// a stalled output holds the drain loop and config writes, the output register keeps one result
module greedy_word_wrap_layout_core #(
  parameter int unsigned WORD_DEPTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  gwl_pkg::cfg_idx_t cfg_index_i,
  input  logic [7:0]       cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  gwl_pkg::in_t     in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output gwl_pkg::out_t    out_data_o
);
  import gwl_pkg::*;

  localparam int unsigned LEN_W = $clog2(WORD_DEPTH);
  // the buffer keeps one entry short of its depth
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(WORD_DEPTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_CHK,
    ST_RD,
    ST_EMIT,
    ST_ADV,
    ST_POST
  } state_e;

  state_e           state_q;
  logic [7:0]       lw_q;
  logic [5:0]       last_row_q;
  logic [LEN_W-1:0] len_q;
  logic [LEN_W-1:0] idx_q;
  logic [7:0]       col_q;
  logic [6:0]       row_q;
  logic             is_sep_q;
  logic             is_nl_q;
  logic             out_valid_q;
  out_t             out_q;

  logic             in_hs;
  logic             ch_nl;
  logic             ch_sep;
  logic [LEN_W-1:0] len_base;
  logic             mem_we;
  logic [LEN_W-1:0] len_d;
  logic             hard_brk;
  logic             flush_req;
  logic [LEN_W-1:0] add_b;
  logic [8:0]       add_sum;
  logic [7:0]       add_sat;
  logic [6:0]       row_adv;
  logic             out_free;
  logic             last_glyph;
  logic [7:0]       rd_data;

  // config registers, written only while idle with no result waiting
  assign cfg_ready_o = (state_q == ST_IDLE) && !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_q       <= LINE_WIDTH_RST;
      last_row_q <= LAST_ROW_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_LINE_WIDTH: lw_q       <= cfg_data_i;
        CFG_LAST_ROW:   last_row_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // intake: first_of_text clears the cursor and word before the char is handled
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_hs      = in_valid_i && in_ready_o;
  assign ch_nl      = (in_data_i.ch == CH_NEWLINE);
  assign ch_sep     = (in_data_i.ch == CH_SPACE) || ch_nl;
  assign len_base   = in_data_i.first_of_text ? '0 : len_q;
  // extra chars beyond the buffer are dropped
  assign mem_we     = in_hs && !ch_sep && (len_base < LEN_MAX);
  assign len_d      = mem_we ? len_base + LEN_W'(1) : len_base;
  // hard break once the word fills a line
  assign hard_brk   = (9'(len_d) >= 9'(lw_q));
  assign flush_req  = ch_sep || in_data_i.last_of_text || hard_brk;

  gwl_word_buf #(
    .DEPTH (WORD_DEPTH),
    .AW    (LEN_W)
  ) u_word_buf (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (len_base),
    .wdata_i (in_data_i.ch),
    .raddr_i (idx_q),
    .rdata_o (rd_data)
  );

  // shared adder operand: glyph offset while draining, one for a space,
  // word length for the wrap test and the cursor advance
  always_comb begin
    case (state_q)
      ST_EMIT: add_b = idx_q;
      ST_POST: add_b = LEN_W'(1);
      default: add_b = len_q;
    endcase
  end

  gwl_col_add #(
    .B_W (LEN_W)
  ) u_col_add (
    .a_i   (col_q),
    .b_i   (add_b),
    .sum_o (add_sum),
    .sat_o (add_sat)
  );

  // row stops one past the last row
  assign row_adv    = (row_q <= 7'(last_row_q)) ? row_q + 7'd1 : row_q;
  assign out_free   = !out_valid_q || out_ready_i;
  assign last_glyph = (idx_q == len_q - LEN_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      idx_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      is_sep_q    <= 1'b0;
      is_nl_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // a new glyph refills the output register, else a taken result empties it
      if (state_q == ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_hs) begin
            len_q    <= len_d;
            is_sep_q <= ch_sep;
            is_nl_q  <= ch_nl;
            if (in_data_i.first_of_text) begin
              col_q <= '0;
              row_q <= '0;
            end
            state_q <= flush_req ? ST_FLUSH : ST_IDLE;
          end
        end
        ST_FLUSH: begin
          if (len_q == '0) begin
            state_q <= ST_POST;
          end else begin
            // word does not fit the rest of the line: wrap
            if (add_sum > 9'(lw_q)) begin
              row_q <= row_adv;
              col_q <= '0;
            end
            state_q <= ST_CHK;
          end
        end
        ST_CHK: begin
          // past the last row the word is dropped
          if (row_q > 7'(last_row_q)) begin
            len_q   <= '0;
            state_q <= ST_POST;
          end else begin
            idx_q   <= '0;
            state_q <= ST_RD;
          end
        end
        ST_RD: begin
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_q.glyph    <= rd_data;
            out_q.cell_col <= add_sat;
            out_q.cell_row <= row_q[5:0];
            out_q.run_end  <= last_glyph;
            if (last_glyph) begin
              state_q <= ST_ADV;
            end else begin
              idx_q   <= idx_q + LEN_W'(1);
              state_q <= ST_RD;
            end
          end
        end
        ST_ADV: begin
          col_q   <= add_sat;
          len_q   <= '0;
          state_q <= ST_POST;
        end
        ST_POST: begin
          if (is_nl_q) begin
            row_q <= row_adv;
            col_q <= '0;
          end else if (is_sep_q && (col_q < lw_q) && (col_q != 8'd0)) begin
            col_q <= add_sat;
          end
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // drawn rows never pass the last row
  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.cell_row <= last_row_q))
    else $error("cell row beyond last row");

  // cursor row saturates one past the largest last row
  a_row_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= 7'd64)
    else $error("cursor row beyond saturation");

  // the final glyph of a word ends the drain and advances the cursor
  a_run_end_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_free && last_glyph) |=> (state_q == ST_ADV && out_data_o.run_end))
    else $error("run end without cursor advance");

  // the word being drained is never empty
  a_busy_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD || state_q == ST_EMIT) |-> (len_q != '0))
    else $error("drain with empty word");

endmodule
